// ===== rtl/pbf_pkg.sv =====
// ----------------------------------------------------------------------------
// pbf_pkg : shared types and constants of the packet block framer
// Command format passed from the front end to the byte sequencer, opcode
// codes, sequencer phases and the fixed block layout constants.
// ----------------------------------------------------------------------------
package pbf_pkg;

  // input opcodes
  localparam logic OP_START = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  // Enhanced Packet Block layout
  localparam logic [31:0] EPB_TYPE        = 32'h0000_0006;
  localparam logic [15:0] EPB_OVERHEAD    = 16'd32;   // header + trailer bytes
  localparam logic [4:0]  HDR_LAST_IDX    = 5'd27;    // 28 header bytes
  localparam logic [1:0]  TRL_LAST_IDX    = 2'd3;     // 4 trailer bytes
  localparam logic [16:0] ALIGN_MASK      = 17'd3;
  localparam logic [15:0] MAX_BLOCK_RESET = 16'd65532;

  typedef enum logic {
    CMD_HEADER = 1'b0,
    CMD_DATA   = 1'b1
  } cmd_kind_t;

  typedef enum logic [1:0] {
    SQ_BODY    = 2'd0,
    SQ_PAD     = 2'd1,
    SQ_TRAILER = 2'd2
  } seq_phase_t;

  // one queued command: a header run or one payload byte, optionally
  // followed by padding and the trailing total length
  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  data;
    logic [31:0] ts;
    logic [15:0] cap;
    logic [15:0] orig;
    logic [15:0] total;
    logic        tail;
    logic [1:0]  pad;
  } cmd_t;

endpackage

// ===== rtl/pbf_front.sv =====
// ----------------------------------------------------------------------------
// pbf_front : input front end
// Takes input beats, holds the frame state and the length limit, works out
// captured and total lengths and pushes one command per beat that makes
// output bytes.
// ----------------------------------------------------------------------------
module pbf_front import pbf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [15:0] in_frame_length,
  input  logic [31:0] in_capture_ms,
  input  logic [7:0]  in_data_byte,
  input  logic        q_full,
  output logic        q_push,
  output cmd_t        q_cmd
);

  logic [15:0] max_len_r;
  logic [15:0] cap_r, cap_nxt;
  logic [15:0] seen_r, seen_nxt;
  logic [15:0] total_r, total_nxt;
  logic        open_r, open_nxt;

  logic        accept;
  logic [15:0] lim_base, lim, cap_lim;
  logic [16:0] padded;
  logic [15:0] start_cap, start_total;
  logic [15:0] seen_inc;
  logic        data_last;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // limit rounded down to a word, floored at the bare overhead
  assign lim_base = {max_len_r[15:2], 2'b00};
  assign lim      = (lim_base < EPB_OVERHEAD) ? EPB_OVERHEAD : lim_base;
  assign cap_lim  = lim - EPB_OVERHEAD;
  assign padded   = ({1'b0, in_frame_length} + ALIGN_MASK) & ~ALIGN_MASK;

  always_comb begin
    if (padded > {1'b0, cap_lim}) begin
      start_cap   = cap_lim;
      start_total = lim;
    end else begin
      start_cap   = in_frame_length;
      start_total = padded[15:0] + EPB_OVERHEAD;
    end
  end

  assign seen_inc  = seen_r + 16'd1;
  assign data_last = (seen_inc == cap_r);

  always_comb begin
    cap_nxt   = cap_r;
    seen_nxt  = seen_r;
    total_nxt = total_r;
    open_nxt  = open_r;
    q_push    = 1'b0;
    q_cmd     = '0;
    if (accept) begin
      unique case (in_opcode)
        OP_START: begin
          cap_nxt     = start_cap;
          total_nxt   = start_total;
          seen_nxt    = '0;
          open_nxt    = (start_cap != 16'd0);
          q_push      = 1'b1;
          q_cmd.kind  = CMD_HEADER;
          q_cmd.ts    = in_capture_ms;
          q_cmd.cap   = start_cap;
          q_cmd.orig  = in_frame_length;
          q_cmd.total = start_total;
          q_cmd.tail  = (start_cap == 16'd0);
          q_cmd.pad   = 2'd0;
        end
        OP_DATA: begin
          // closed frame: beat is dropped
          if (open_r) begin
            seen_nxt    = seen_inc;
            open_nxt    = !data_last;
            q_push      = 1'b1;
            q_cmd.kind  = CMD_DATA;
            q_cmd.data  = in_data_byte;
            q_cmd.total = total_r;
            q_cmd.tail  = data_last;
            q_cmd.pad   = 2'd0 - cap_r[1:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_BLOCK_RESET;
      cap_r     <= '0;
      seen_r    <= '0;
      total_r   <= '0;
      open_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_len_r <= cfg_wdata;
      end
      cap_r   <= cap_nxt;
      seen_r  <= seen_nxt;
      total_r <= total_nxt;
      open_r  <= open_nxt;
    end
  end

endmodule

// ===== rtl/pbf_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// pbf_cmd_queue : command queue
// Small FIFO between front end and byte sequencer; head is read directly.
// ----------------------------------------------------------------------------
module pbf_cmd_queue import pbf_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  output logic head_valid,
  output cmd_t head_cmd,
  input  logic pop
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = mem[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    priority if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== rtl/pbf_back.sv =====
// ----------------------------------------------------------------------------
// pbf_back : byte sequencer
// Expands the queue head into bytes (header, payload, padding, trailer) and
// drives the registered output channel, one byte per cycle when not stalled.
// ----------------------------------------------------------------------------
module pbf_back import pbf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  cmd_t       head_cmd,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_block_end
);

  seq_phase_t  phase_r, phase_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r, byte_nxt;
  logic        out_end_r, end_nxt;
  logic        load, go;
  logic [31:0] hdr_word;
  logic [31:0] sel_word;
  logic [7:0]  sel_byte;

  assign load = !out_valid_r || out_ready;
  assign go   = load && head_valid;

  // header word by index
  always_comb begin
    unique case (cnt_r[4:2])
      3'd0:    hdr_word = EPB_TYPE;
      3'd1:    hdr_word = {16'd0, head_cmd.total};
      3'd4:    hdr_word = head_cmd.ts;
      3'd5:    hdr_word = {16'd0, head_cmd.cap};
      3'd6:    hdr_word = {16'd0, head_cmd.orig};
      default: hdr_word = 32'd0;   // interface id, timestamp high
    endcase
  end

  assign sel_word = (phase_r == SQ_TRAILER) ? {16'd0, head_cmd.total} : hdr_word;

  // little-endian byte lane
  always_comb begin
    unique case (cnt_r[1:0])
      2'd0: sel_byte = sel_word[7:0];
      2'd1: sel_byte = sel_word[15:8];
      2'd2: sel_byte = sel_word[23:16];
      2'd3: sel_byte = sel_word[31:24];
      default: sel_byte = 8'd0;
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    pop       = 1'b0;
    byte_nxt  = 8'd0;
    end_nxt   = 1'b0;
    if (go) begin
      unique case (phase_r)
        SQ_BODY: begin
          if (head_cmd.kind == CMD_HEADER) begin
            byte_nxt = sel_byte;
          end else begin
            byte_nxt = head_cmd.data;
          end
          if (head_cmd.kind == CMD_HEADER && cnt_r != HDR_LAST_IDX) begin
            cnt_nxt = cnt_r + 5'd1;
          end else begin
            cnt_nxt = '0;
            if (head_cmd.tail) begin
              phase_nxt = (head_cmd.pad != 2'd0) ? SQ_PAD : SQ_TRAILER;
            end else begin
              pop = 1'b1;
            end
          end
        end
        SQ_PAD: begin
          if (cnt_r[1:0] == head_cmd.pad - 2'd1) begin
            cnt_nxt   = '0;
            phase_nxt = SQ_TRAILER;
          end else begin
            cnt_nxt = cnt_r + 5'd1;
          end
        end
        SQ_TRAILER: begin
          byte_nxt = sel_byte;
          if (cnt_r[1:0] == TRL_LAST_IDX) begin
            end_nxt   = 1'b1;
            pop       = 1'b1;
            cnt_nxt   = '0;
            phase_nxt = SQ_BODY;
          end else begin
            cnt_nxt = cnt_r + 5'd1;
          end
        end
        default: begin
          phase_nxt = SQ_BODY;
          cnt_nxt   = '0;
        end
      endcase
    end
  end

  assign out_valid_nxt = load ? head_valid : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= SQ_BODY;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_byte_r <= byte_nxt;
      out_end_r  <= end_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_block_end = out_end_r;

endmodule

// ===== rtl/pcapng_packet_block_framer.sv =====
// ----------------------------------------------------------------------------
// pcapng_packet_block_framer : pcapng Enhanced Packet Block writer
// Wraps captured frames as Enhanced Packet Blocks, emitted as a byte stream.
// ----------------------------------------------------------------------------
// A start beat (opcode 0) carries frame length and a millisecond timestamp
// and produces the 28-byte header: type 6, total length, interface 0,
// timestamp high 0, timestamp low, captured length, original length. Data
// beats (opcode 1) pass one byte each until the captured length is reached;
// the beat with the last byte also produces zero padding to a 4-byte
// boundary and the repeated total length, with out_block_end high on its
// final byte. The captured length is cut so the block never exceeds
// max_block_length (rounded down to a word, floored at 32); data beats with
// no open frame are dropped, and a start beat abandons any open frame.
// The output sequencer emits one byte per cycle while out_ready accepts it;
// a payload beat yields one byte, a start beat 28 bytes (32 for an empty
// capture) and the closing data beat 5 to 8 bytes. The input is accepted
// one beat per cycle while the QUEUE_DEPTH-entry command queue has room;
// a header run stalls the input once the queue has filled behind it.
// An accepted beat is held in the command queue, then in the output register.
// max_block_length is written through cfg_we/cfg_wdata and resets to 65532;
// write it only while the block is idle.
// ----------------------------------------------------------------------------
module pcapng_packet_block_framer import pbf_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: max_block_length
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [15:0] in_frame_length,
  input  logic [31:0] in_capture_ms,
  input  logic [7:0]  in_data_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_block_end
);

  // front end -> queue
  logic q_full;
  logic q_push;
  cmd_t q_cmd;

  // queue -> sequencer
  logic head_valid;
  cmd_t head_cmd;
  logic pop;

  // front end: frame state, length math, one command per productive beat
  pbf_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_frame_length (in_frame_length),
    .in_capture_ms   (in_capture_ms),
    .in_data_byte    (in_data_byte),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_cmd           (q_cmd)
  );

  // decouples input from the byte-rate output side
  pbf_cmd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .full       (q_full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop)
  );

  // back end: expands commands into bytes, registered output
  pbf_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_valid    (head_valid),
    .head_cmd      (head_cmd),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_block_end (out_block_end)
  );

endmodule

// ===== rtl/pbf_checker.sv =====
// ----------------------------------------------------------------------------
// pbf_checker : port-level checks of the packet block framer
// Watches the top-level ports and flags framing and handshake slips.
// ----------------------------------------------------------------------------
module pbf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_block_end
);

  // set after reset and after each block end: next byte must open a header
  logic at_block_start_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_block_start_r <= 1'b1;
    end else if (out_valid && out_ready) begin
      at_block_start_r <= out_block_end;
    end
  end

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_block_end))
    else $error("output beat changed while stalled");

  // total length never reaches the top byte of the trailer word
  a_end_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_block_end |-> out_byte == 8'h00)
    else $error("block end byte is not zero");

  // every block starts with the type byte
  a_block_starts_with_type: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && at_block_start_r |-> out_byte == 8'h06 && !out_block_end)
    else $error("block does not start with type 6");

  // reset empties the output register
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind pcapng_packet_block_framer pbf_checker u_pbf_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_byte      (out_byte),
  .out_block_end (out_block_end)
);
